// ----- hdl/canonical_line_editor_assert.svh -----
// Assertion macros used by the line editor top level.
`ifndef CANONICAL_LINE_EDITOR_ASSERT_SVH
`define CANONICAL_LINE_EDITOR_ASSERT_SVH
// Checks that an implication holds at every clock edge outside reset.
`define CLE_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Checks that a condition implies a property in the following cycle.
`define CLE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ----- hdl/cle_pkg.sv -----
// Package with types and constants for the canonical line editor.
package cle_pkg;
   localparam int LineLen = 64;
   localparam int AddrW = $clog2(LineLen);
   localparam int FillW = $clog2(LineLen + 1);

   localparam logic [2:0] RegMode  = 3'd0;
   localparam logic [2:0] RegIntr  = 3'd1;
   localparam logic [2:0] RegQuit  = 3'd2;
   localparam logic [2:0] RegSusp  = 3'd3;
   localparam logic [2:0] RegEof   = 3'd4;
   localparam logic [2:0] RegErase = 3'd5;
   localparam logic [2:0] RegKill  = 3'd6;
   localparam logic [2:0] RegWerase = 3'd7;

   localparam logic OpReceive = 1'b0;
   localparam logic OpRead    = 1'b1;

   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChBs    = 8'h08;
   localparam logic [7:0] ChDel   = 8'h7F;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChCaret = 8'h5E;
   localparam logic [7:0] ChAt    = 8'h40;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic       echo_valid;
      logic [5:0] erase_count;
      logic [1:0] signal_code;
      logic       line_ready;
      logic [5:0] line_length;
      logic       end_of_file;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       overrun;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [6:0] mode_flags;
      logic [7:0] intr_char;
      logic [7:0] quit_char;
      logic [7:0] susp_char;
      logic [7:0] eof_char;
      logic [7:0] erase_char;
      logic [7:0] kill_char;
      logic [7:0] werase_char;
   } cfg_type;

   function automatic logic [5:0] sat63(input logic [FillW-1:0] v);
      logic [5:0] r;
      if (v > FillW'(63)) r = 6'd63;
      else r = v[5:0];
      return r;
   endfunction
endpackage

// ----- hdl/cle_ram.sv -----
// Generic single-port RAM with registered read.
module cle_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data_ff <= mem_ff[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/cle_csr.sv -----
// Configuration register file of the line editor.
module cle_csr import cle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [2:0] wr_index,
   input  logic [7:0] wr_data,
   output cfg_type    cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            RegMode:   cfg_in.mode_flags  = wr_data[6:0];
            RegIntr:   cfg_in.intr_char   = wr_data;
            RegQuit:   cfg_in.quit_char   = wr_data;
            RegSusp:   cfg_in.susp_char   = wr_data;
            RegEof:    cfg_in.eof_char    = wr_data;
            RegErase:  cfg_in.erase_char  = wr_data;
            RegKill:   cfg_in.kill_char   = wr_data;
            RegWerase: cfg_in.werase_char = wr_data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode_flags: 7'd127, intr_char: 8'd3, quit_char: 8'd28,
                     susp_char: 8'd26, eof_char: 8'd4, erase_char: 8'd127,
                     kill_char: 8'd21, werase_char: 8'd23};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
   assign cfg = cfg_ff;
endmodule

// ----- hdl/canonical_line_editor.sv -----
// Top level of the canonical line editor: sequencer, configuration registers, line store and result assembly.
// A receive passes from decode straight to emission; a read of a pending byte first waits in
// S_RDWAIT for the store data, and a word erase alternates scan read and scan test for each scanned byte.
// One request is taken at a time; results leave one per cycle while rsp_stall is low, up to
// four, and the sequencer then returns to idle to take the next request. Reset is synchronous
// and active high; it restores register defaults and empties the line, store left as is.
module canonical_line_editor import cle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
`include "canonical_line_editor_assert.svh"

   // The state machine walks through decode, an optional read wait or word-erase scan
   // (read, then test) and then the emission of one to four results.
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_RDWAIT, S_SCAN_RD, S_SCAN_TEST, S_EMIT
   } state_type;

   cfg_type cfg;
   cle_csr u_csr (
      .clock(clock), .reset(reset), .wr_en(csr_valid && csr_ready),
      .wr_index(csr_index), .wr_data(csr_data), .cfg(cfg)
   );
   assign csr_ready = 1'b1;

   state_type        state_ff, state_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [FillW-1:0] rpos_ff, rpos_in;
   logic             pend_ff, pend_in;
   req_type          req_ff, req_in;
   logic [7:0]       echo_ff [4];
   logic [7:0]       echo_in [4];
   logic [2:0]       ne_ff, ne_in;
   logic [1:0]       k_ff, k_in;
   logic             skip_sp_ff, skip_sp_in;
   logic [FillW-1:0] erased_ff, erased_in;
   rsp_type          base_ff, base_in;

   logic             ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [7:0]       ram_wdata, ram_rdata;

   cle_ram #(.Width(8), .Depth(LineLen)) u_store (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   logic [7:0] c;
   logic       is_sig;
   logic [FillW-1:0] fill_m1;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      rpos_in    = rpos_ff;
      pend_in    = pend_ff;
      req_in     = req_ff;
      echo_in    = echo_ff;
      ne_in      = ne_ff;
      k_in       = k_ff;
      skip_sp_in = skip_sp_ff;
      erased_in  = erased_ff;
      base_in    = base_ff;
      ram_we     = 1'b0;
      ram_addr   = rpos_ff[AddrW-1:0];
      ram_wdata  = 8'd0;
      fill_m1    = fill_ff - FillW'(1);
      c          = req_ff.rx_byte;
      if (cfg.mode_flags[5] && c == ChCr) c = ChNl;
      is_sig = cfg.mode_flags[4] && (req_ff.rx_byte == cfg.intr_char ||
               req_ff.rx_byte == cfg.quit_char || req_ff.rx_byte == cfg.susp_char);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               base_in   = '0;
               ne_in     = 3'd0;
               k_in      = 2'd0;
               erased_in = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            if (req_ff.operation == OpRead) begin
               if (pend_ff && rpos_ff < fill_ff) begin
                  // Fetch the byte; the store answers in the following cycle.
                  state_in = S_RDWAIT;
               end else if (pend_ff) begin
                  pend_in = 1'b0; fill_in = '0; rpos_in = '0;
               end
            end else if (pend_ff) begin
               base_in.overrun = 1'b1;
            end else if (is_sig) begin
               if (req_ff.rx_byte == cfg.intr_char) begin
                  base_in.signal_code = 2'd1; echo_in[1] = 8'h43;
               end else if (req_ff.rx_byte == cfg.quit_char) begin
                  base_in.signal_code = 2'd2; echo_in[1] = 8'h5C;
               end else begin
                  base_in.signal_code = 2'd3; echo_in[1] = 8'h5A;
               end
               echo_in[0] = ChCaret; echo_in[2] = ChCr; echo_in[3] = ChNl;
               if (cfg.mode_flags[0]) ne_in = 3'd4;
               fill_in = '0; rpos_in = '0;
            end else if (req_ff.rx_byte == cfg.eof_char) begin
               if (fill_ff == '0) begin
                  base_in.end_of_file = 1'b1;
               end else begin
                  base_in.line_ready = 1'b1;
                  base_in.line_length = sat63(fill_ff);
                  pend_in = 1'b1; rpos_in = '0;
               end
            end else if (c == cfg.erase_char || c == ChBs || c == ChDel) begin
               if (fill_ff != '0) begin
                  fill_in = fill_m1;
                  if (cfg.mode_flags[1]) erased_in = FillW'(1);
               end
            end else if (c == cfg.kill_char) begin
               fill_in = '0;
               if (cfg.mode_flags[2]) begin
                  erased_in = fill_ff;
                  echo_in[0] = ChNl; echo_in[1] = ChCr; ne_in = 3'd2;
               end
            end else if (c == cfg.werase_char) begin
               skip_sp_in = 1'b1;
               state_in   = S_SCAN_RD;
            end else begin
               if (cfg.mode_flags[0]) begin
                  if (c == ChNl) begin
                     if (cfg.mode_flags[6]) begin
                        echo_in[0] = ChCr; echo_in[1] = ChNl; ne_in = 3'd2;
                     end else begin
                        echo_in[0] = ChNl; ne_in = 3'd1;
                     end
                  end else if (c < ChSpace && c != ChTab) begin
                     if (cfg.mode_flags[3]) begin
                        echo_in[0] = ChCaret; echo_in[1] = c + ChAt; ne_in = 3'd2;
                     end
                  end else begin
                     echo_in[0] = c; ne_in = 3'd1;
                  end
               end
               if (fill_ff < FillW'(LineLen - 1)) begin
                  ram_we    = 1'b1;
                  ram_addr  = fill_ff[AddrW-1:0];
                  ram_wdata = c;
                  fill_in   = fill_ff + FillW'(1);
               end
               if (c == ChNl) begin
                  base_in.line_ready = 1'b1;
                  base_in.line_length = sat63(fill_in);
                  pend_in = 1'b1; rpos_in = '0;
               end
            end
         end
         S_RDWAIT: begin
            // Store data for the read position is now registered.
            if (!base_ff.read_valid) begin
               base_in.read_valid = 1'b1;
            end else begin
               base_in.read_byte = ram_rdata;
               rpos_in = rpos_ff + FillW'(1);
               if (rpos_ff + FillW'(1) >= fill_ff) begin
                  pend_in = 1'b0; fill_in = '0; rpos_in = '0;
               end
               state_in = S_EMIT;
            end
         end
         S_SCAN_RD: begin
            if (fill_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               ram_addr = fill_m1[AddrW-1:0];
               state_in = S_SCAN_TEST;
            end
         end
         S_SCAN_TEST: begin
            ram_addr = fill_m1[AddrW-1:0];
            state_in = S_SCAN_RD;
            if (skip_sp_ff && ram_rdata == ChSpace) begin
               fill_in = fill_m1;
               if (cfg.mode_flags[1]) erased_in = erased_ff + FillW'(1);
            end else if (ram_rdata != ChSpace) begin
               skip_sp_in = 1'b0;
               fill_in = fill_m1;
               if (cfg.mode_flags[1]) erased_in = erased_ff + FillW'(1);
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (ne_ff <= 3'({1'b0, k_ff} + 3'd1)) state_in = S_IDLE;
               k_in = k_ff + 2'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         rpos_ff  <= '0;
         pend_ff  <= 1'b0;
         k_ff     <= '0;
         ne_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rpos_ff  <= rpos_in;
         pend_ff  <= pend_in;
         k_ff     <= k_in;
         ne_ff    <= ne_in;
      end
      req_ff     <= req_in;
      echo_ff    <= echo_in;
      skip_sp_ff <= skip_sp_in;
      erased_ff  <= erased_in;
      base_ff    <= base_in;
   end

   // Result assembly: shared fields repeat, erase count on the first result only, the echo walks the list.
   always_comb begin
      rsp_data = base_ff;
      rsp_data.echo_valid  = ({1'b0, k_ff} < ne_ff);
      rsp_data.echo_byte   = rsp_data.echo_valid ? echo_ff[k_ff] : 8'd0;
      rsp_data.erase_count = (k_ff == 2'd0) ? sat63(erased_ff) : 6'd0;
      rsp_data.last        = (ne_ff <= 3'({1'b0, k_ff} + 3'd1));
   end
   assign rsp_valid = (state_ff == S_EMIT);
   assign req_stall = (state_ff != S_IDLE);

   `CLE_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff < FillW'(LineLen),
      "line fill beyond store")
   `CLE_ASSERT_IMPL(a_rpos_bound, clock, reset, pend_ff, rpos_ff < fill_ff,
      "read position past line end")
   `CLE_ASSERT_NEXT(a_last_leaves, clock, reset, rsp_valid && !rsp_stall && rsp_data.last,
      state_ff == S_IDLE, "sequencer did not return after last result")
endmodule
